### rtl/core/ffba_pkg.sv
// Package for the first-fit block allocator: status codes, commands,
// register indexes and the result word type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;
    localparam logic       CMD_ALLOC   = 1'b0;
    localparam logic       CMD_RELEASE = 1'b1;
    localparam logic       REG_BASE    = 1'b0;
    localparam logic       REG_SIZE    = 1'b1;
    localparam int         CFG_IDX_W   = 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_address;
        logic [31:0] granted_length;
    } result_t;
endpackage
`default_nettype wire

### rtl/core/ffba_table.sv
// Entry table memory for the allocator: start, length and used mark.
// One write port and one registered read port. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none
module ffba_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int IDX_W = 6
) (
    input  wire              aclk,
    input  wire              wr_en,
    input  wire [IDX_W-1:0]  wr_idx,
    input  wire [31:0]       wr_start,
    input  wire [31:0]       wr_length,
    input  wire              wr_used,
    input  wire [IDX_W-1:0]  rd_idx,
    output logic [31:0]      rd_start,
    output logic [31:0]      rd_length,
    output logic             rd_used
);
    logic [64:0] mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_used, wr_length, wr_start};
        end
        {rd_used, rd_length, rd_start} <= mem[rd_idx];
    end
endmodule
`default_nettype wire

### rtl/core/first_fit_block_allocator_top.sv
// Top level of the first-fit allocator: sequencer over the entry table.
// Depends on ffba_pkg and ffba_table.
`timescale 1ns / 1ps
`default_nettype none
// Usage: one word on the s_ channel is a request (allocate or release); one
// word on the m_ channel is its result. Configuration writes on cfg_ set
// region_base (index 0) and region_size (index 1); writing region_size
// re-creates the table as one free entry. Write only while idle.
// The block holds one request at a time: s_axis_tready is low from
// acceptance until the result is taken. An allocate reads the table one
// entry at a time through the single table read port, each entry read and
// then checked in a separate state. A release scans the same way, then
// merges, each merge copying the later entries down one at a time.
// After reset the table is one free entry {0, 0}. While the receiver stalls
// the result stays in the m_ register and no new request is taken.
module first_fit_block_allocator_top #(
    parameter int MAX_ENTRIES = 64,
    parameter int GRAIN_BYTES = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // bits: [31:0] request_size, [63:32] release_address
    input  wire [63:0]  s_axis_tdata,
    // bits: [0] command
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // bits: [1:0] status, [33:2] granted_address, [65:34] granted_length,
    // [71:66] zero
    output logic [71:0] m_axis_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [31:0]  cfg_data
);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_MRD   = 4'd5;
    localparam logic [3:0] S_MCHK  = 4'd6;
    localparam logic [3:0] S_SRD   = 4'd7;
    localparam logic [3:0] S_SWR   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_MRD2  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [31:0]      base_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next, k_reg, k_next;
    logic             cmd_reg;
    logic [32:0]      want_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      p_start_reg, p_length_reg, p_start_next, p_length_next;
    logic             p_used_reg, p_used_next;
    ffba_pkg::result_t res_reg, res_next;
    logic [31:0]      h_start_reg, h_length_reg, h_start_next, h_length_next;
    logic             init_reg, init_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx, rd_idx;
    logic [31:0]      wr_start, wr_length, rd_start, rd_length;
    logic             wr_used, rd_used;

    ffba_table #(.MAX_ENTRIES(MAX_ENTRIES), .IDX_W(IDX_W)) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_start(wr_start),
        .wr_length(wr_length), .wr_used(wr_used), .rd_idx(rd_idx),
        .rd_start(rd_start), .rd_length(rd_length), .rd_used(rd_used)
    );

    // Rounding: add GRAIN-1 in 33 bits, then snap down to the grain.
    logic [32:0] sum33;
    logic [32:0] rounded;
    assign sum33   = {1'b0, s_axis_tdata[31:0]} + 33'(GRAIN_BYTES - 1);
    assign rounded = (sum33 / 33'(GRAIN_BYTES)) * 33'(GRAIN_BYTES);

    // A configuration word takes precedence over a request word in the same cycle.
    assign s_axis_tready = (state_reg == S_IDLE) && !init_reg && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE) && !init_reg;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {6'd0, res_reg.granted_length,
                            res_reg.granted_address, res_reg.status};

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        p_start_next  = p_start_reg;
        p_length_next = p_length_reg;
        p_used_next   = p_used_reg;
        h_start_next  = h_start_reg;
        h_length_next = h_length_reg;
        res_next      = res_reg;
        init_next     = init_reg;
        wr_en         = 1'b0;
        wr_idx        = i_reg[IDX_W-1:0];
        wr_start      = rd_start;
        wr_length     = rd_length;
        wr_used       = rd_used;
        rd_idx        = i_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (init_reg) begin
                    wr_en     = 1'b1;
                    wr_idx    = '0;
                    wr_start  = h_start_reg;
                    wr_length = h_length_reg;
                    wr_used   = 1'b0;
                    count_next = CNT_W'(1);
                    init_next = 1'b0;
                end else if (cfg_valid && cfg_index == 8'(ffba_pkg::REG_SIZE)) begin
                    h_start_next  = base_reg;
                    h_length_next = cfg_data;
                    init_next     = 1'b1;
                end else if (s_axis_tvalid && s_axis_tready) begin
                    i_next = '0;
                    res_next = '{status: ffba_pkg::ST_NO_FIT,
                                 granted_address: 32'd0, granted_length: 32'd0};
                    if (s_axis_tuser == ffba_pkg::CMD_RELEASE) begin
                        res_next.status = ffba_pkg::ST_NOT_FND;
                        state_next = S_RD;
                    end else if (s_axis_tdata[31:0] == 32'd0 || rounded[32]) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (i_reg >= count_reg) state_next = S_OUT;
                else state_next = S_CHK;
            end
            S_CHK: begin
                if (cmd_reg == ffba_pkg::CMD_RELEASE) begin
                    if (rd_start == addr_reg) begin
                        wr_en   = 1'b1;
                        wr_used = 1'b0;
                        res_next.status = ffba_pkg::ST_OK;
                        i_next  = '0;
                        state_next = S_MRD;
                    end else begin
                        i_next = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                end else if (rd_used || {1'b0, rd_length} < want_reg) begin
                    i_next = i_reg + 1'b1;
                    state_next = S_RD;
                end else if ({1'b0, rd_length} > want_reg && count_reg >= MAX_CNT) begin
                    res_next.status = ffba_pkg::ST_FULL;
                    state_next = S_OUT;
                end else begin
                    wr_en     = 1'b1;
                    wr_used   = 1'b1;
                    wr_length = want_reg[31:0];
                    res_next  = '{status: ffba_pkg::ST_OK,
                                  granted_address: rd_start,
                                  granted_length: want_reg[31:0]};
                    h_start_next  = rd_start + want_reg[31:0];
                    h_length_next = rd_length - want_reg[31:0];
                    state_next = ({1'b0, rd_length} > want_reg) ? S_SPLIT : S_OUT;
                end
            end
            S_SPLIT: begin
                wr_en     = 1'b1;
                wr_idx    = count_reg[IDX_W-1:0];
                wr_start  = h_start_reg;
                wr_length = h_length_reg;
                wr_used   = 1'b0;
                count_next = count_reg + 1'b1;
                state_next = S_OUT;
            end
            // Merge pass: p_* holds entry i, next entry read at i+1.
            S_MRD: begin
                if (i_reg + 1'b1 >= count_reg) state_next = S_OUT;
                else state_next = S_MRD2;
            end
            S_MRD2: begin
                p_start_next  = rd_start;
                p_length_next = rd_length;
                p_used_next   = rd_used;
                rd_idx     = IDX_W'(i_reg + 1'b1);
                state_next = S_MCHK;
            end
            S_MCHK: begin
                if (!p_used_reg && !rd_used && p_start_reg + p_length_reg == rd_start) begin
                    wr_en     = 1'b1;
                    wr_start  = p_start_reg;
                    wr_length = p_length_reg + rd_length;
                    wr_used   = 1'b0;
                    p_length_next = p_length_reg + rd_length;
                    k_next = i_reg + 1'b1;
                    state_next = S_SRD;
                end else begin
                    i_next = i_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_SRD: begin
                rd_idx = IDX_W'(k_reg + 1'b1);
                if (k_reg + 1'b1 >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_MRD;
                end else begin
                    state_next = S_SWR;
                end
            end
            S_SWR: begin
                wr_en  = 1'b1;
                wr_idx = k_reg[IDX_W-1:0];
                k_next = k_reg + 1'b1;
                state_next = S_SRD;
            end
            S_OUT: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            count_reg <= CNT_W'(1);
            init_reg  <= 1'b1;
            h_start_reg  <= '0;
            h_length_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            init_reg  <= init_next;
            h_start_reg  <= h_start_next;
            h_length_reg <= h_length_next;
            if (cfg_valid && cfg_ready && cfg_index == 8'(ffba_pkg::REG_BASE)) begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        k_reg <= k_next;
        p_start_reg  <= p_start_next;
        p_length_reg <= p_length_next;
        p_used_reg   <= p_used_next;
        res_reg      <= res_next;
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg  <= s_axis_tuser;
            want_reg <= rounded;
            addr_reg <= s_axis_tdata[63:32];
        end
    end
endmodule
`default_nettype wire

### rtl/core/ffba_checker.sv
// Port checker for the allocator top level, attached by bind.
// Depends on first_fit_block_allocator_top only through its ports.
`timescale 1ns / 1ps
`default_nettype none
module ffba_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [71:0] m_axis_tdata
);
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed under stall");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result waits");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[65:2] == 64'd0)
        else $error("failed result carries an address");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[71:66] == 6'd0)
        else $error("padding bits not zero");
endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
